>>> hw/rtl/prq_pkg.sv
// Shared constants, types and helpers of the priority request queue.
package prq_pkg;

    localparam int NUM_PLAYERS = 4;
    localparam int LIST_DEPTH  = 5;

    localparam int OP_W    = 2;
    localparam int PLY_W   = 2;
    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int FADE_W  = 8;
    localparam int DEPTH_W = 3;

    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int PIDX_W    = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;
    localparam int RAM_DEPTH = NUM_PLAYERS * LIST_DEPTH;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam int IN_FIELDS_W  = PLY_W + ID_W + PRIO_W + FADE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = PLY_W + ID_W + PRIO_W + FADE_W + DEPTH_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_QUEUE   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STOP  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               action;
        logic [PLY_W-1:0]   player;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [FADE_W-1:0]  fade;
        logic [DEPTH_W-1:0] depth;
        logic               last;
    } t_result;

    // Each player owns LIST_DEPTH consecutive words of the entry memory.
    function automatic logic [ADDR_W-1:0] f_addr(input logic [PLY_W-1:0] player,
                                                 input logic [CNT_W-1:0] idx);
        f_addr = ADDR_W'(int'(player) * LIST_DEPTH + int'(idx));
    endfunction

endpackage

>>> hw/rtl/priority_request_queue_top.sv
// Per-player sorted request lists with start and stop generation.
//
// Input stream: one command per transfer. tuser carries the opcode (queue,
// unqueue, clear); tdata carries player, seq_id, prio and fade. Output stream:
// start or stop actions, tuser is the action, tlast marks the final result
// of a command. A command yields zero, one or two results.
//
// The block handles one command at a time and drops s_axis_tready after it
// accepts a queue or unqueue command until that command is finished. All list
// entries live in one memory with one write and one read port, and a small
// sequencer walks it: it scans the list, shifts the entries behind the
// insertion or removal point where needed, writes a queued entry and then
// hands over the results. A clear is done as it is accepted and leaves
// s_axis_tready high.
//
// Results sit in an output register; a stalled receiver holds the sequencer
// only when it has a further result to hand over. Reset empties all lists
// at once (the counts clear, memory contents are never read beyond them).
module priority_request_queue_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // player, seq_id, prio, fade, zero fill (lowest bit first)
    input  logic [prq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [prq_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_player, out_seq_id, out_prio, out_fade, depth_after, zero fill
    output logic [prq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // action
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    import prq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_MOVE  = 6'b000100,
        S_PUT   = 6'b001000,
        S_STOP  = 6'b010000,
        S_START = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_counts [NUM_PLAYERS];

    logic [OP_W-1:0]   r_op;
    logic [PLY_W-1:0]  r_player;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic [FADE_W-1:0] r_fade;

    logic [CNT_W-1:0] r_cnt_cur, r_idx, r_chk_idx, r_fpos, r_ppos, r_pos;
    logic [CNT_W-1:0] r_dst, r_end, r_wr_dst;
    logic             r_chk_v, r_found, r_pfound, r_mv_more, r_wr_v, r_mv_up;
    logic             r_head_pend, r_start_ram;

    t_result r_out, n_out;
    logic    r_ovalid, out_load, out_free;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    t_entry            ram_wdata, ram_rdata;

    logic [PLY_W-1:0]  in_player;
    logic [ID_W-1:0]   in_id;
    logic [PRIO_W-1:0] in_prio;
    logic [FADE_W-1:0] in_fade;
    logic              in_fire, ply_ok, scan_done;

    logic [CNT_W-1:0] q_pos, q_newcnt, u_pos, u_newcnt, mv_src;
    logic             q_drop;

    assign {in_fade, in_prio, in_id, in_player} = s_axis_tdata[IN_FIELDS_W-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign ply_ok        = int'(in_player) < NUM_PLAYERS;

    assign scan_done = (r_idx == r_cnt_cur) && !r_chk_v;

    // Insertion point: first entry of equal or lower priority, else the tail.
    assign q_pos    = r_pfound ? r_ppos : r_cnt_cur;
    assign q_drop   = int'(q_pos) >= LIST_DEPTH;
    assign q_newcnt = (r_cnt_cur == CNT_W'(LIST_DEPTH)) ? r_cnt_cur
                                                        : r_cnt_cur + CNT_W'(1);
    assign u_pos    = r_found ? r_fpos : r_cnt_cur;
    assign u_newcnt = r_found ? r_cnt_cur - CNT_W'(1) : r_cnt_cur;
    assign mv_src   = r_mv_up ? r_dst + CNT_W'(1) : r_dst - CNT_W'(1);

    assign out_free = !r_ovalid || m_axis_tready;

    prq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = f_addr(r_player, r_wr_dst);
        ram_raddr = f_addr(r_player, r_idx);
        ram_wdata = ram_rdata;
        out_load  = 1'b0;
        n_out     = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && ply_ok &&
                    (s_axis_tuser == OP_QUEUE || s_axis_tuser == OP_UNQUEUE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_re = (r_idx != r_cnt_cur);
                if (scan_done) begin
                    if (r_op == OP_QUEUE) begin
                        priority if (r_found) begin
                            n_state = (r_fpos == '0) ? S_START : S_IDLE;
                        end else if (q_drop) begin
                            n_state = S_IDLE;
                        end else if (q_newcnt > q_pos + CNT_W'(1)) begin
                            n_state = S_MOVE;
                        end else begin
                            n_state = S_PUT;
                        end
                    end else begin
                        priority if (r_found && (r_fpos + CNT_W'(1) < r_cnt_cur)) begin
                            n_state = S_MOVE;
                        end else if (u_pos == '0) begin
                            n_state = S_STOP;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_MOVE: begin
                // Read the neighbor of one slot while writing the slot before it.
                ram_re    = r_mv_more;
                ram_raddr = f_addr(r_player, mv_src);
                ram_we    = r_wr_v;
                if (!r_mv_more && !r_wr_v) begin
                    if (r_op == OP_QUEUE) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = (r_pos == '0) ? S_STOP : S_IDLE;
                    end
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(r_player, r_pos);
                ram_wdata = '{id: r_id, prio: r_prio};
                n_state   = (r_pos == '0) ? S_START : S_IDLE;
            end
            S_STOP: begin
                // Fetch the new head so that the following start can use it.
                ram_re    = 1'b1;
                ram_raddr = f_addr(r_player, '0);
                if (out_free) begin
                    out_load = 1'b1;
                    n_out    = '{action: ACT_STOP, player: r_player, id: '0, prio: '0,
                                 fade: r_fade, depth: DEPTH_W'(r_cnt_cur),
                                 last: !r_head_pend};
                    n_state  = r_head_pend ? S_START : S_IDLE;
                end
            end
            S_START: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out    = '{action: ACT_START, player: r_player,
                                 id: r_start_ram ? ram_rdata.id : r_id,
                                 prio: r_start_ram ? ram_rdata.prio : r_prio,
                                 fade: r_fade, depth: DEPTH_W'(r_cnt_cur),
                                 last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_chk_v     <= 1'b0;
            r_found     <= 1'b0;
            r_pfound    <= 1'b0;
            r_mv_more   <= 1'b0;
            r_wr_v      <= 1'b0;
            r_mv_up     <= 1'b0;
            r_head_pend <= 1'b0;
            r_start_ram <= 1'b0;
            r_idx       <= '0;
            r_cnt_cur   <= '0;
            for (int k = 0; k < NUM_PLAYERS; k++) begin
                r_counts[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (in_fire) begin
                r_cnt_cur <= r_counts[PIDX_W'(in_player)];
                r_idx     <= '0;
                r_chk_v   <= 1'b0;
                r_found   <= 1'b0;
                r_pfound  <= 1'b0;
                if (ply_ok && s_axis_tuser == OP_CLEAR) begin
                    r_counts[PIDX_W'(in_player)] <= '0;
                end
            end

            if (r_state == S_SCAN) begin
                if (r_idx != r_cnt_cur) begin
                    r_idx     <= r_idx + CNT_W'(1);
                    r_chk_idx <= r_idx;
                    r_chk_v   <= 1'b1;
                end else begin
                    r_chk_v <= 1'b0;
                end
                if (r_chk_v) begin
                    if (!r_found && ram_rdata.id == r_id) begin
                        r_found <= 1'b1;
                        r_fpos  <= r_chk_idx;
                    end
                    if (!r_pfound && r_prio >= ram_rdata.prio) begin
                        r_pfound <= 1'b1;
                        r_ppos   <= r_chk_idx;
                    end
                end
                if (scan_done) begin
                    r_mv_more <= 1'b1;
                    r_wr_v    <= 1'b0;
                    if (r_op == OP_QUEUE) begin
                        r_pos       <= q_pos;
                        r_start_ram <= 1'b0;
                        r_mv_up     <= 1'b0;
                        r_dst       <= q_newcnt - CNT_W'(1);
                        r_end       <= q_pos + CNT_W'(1);
                        if (!r_found && !q_drop) begin
                            r_cnt_cur                    <= q_newcnt;
                            r_counts[PIDX_W'(r_player)] <= q_newcnt;
                        end
                    end else begin
                        r_pos       <= u_pos;
                        r_start_ram <= 1'b1;
                        r_mv_up     <= 1'b1;
                        r_head_pend <= (u_newcnt != '0);
                        r_cnt_cur   <= u_newcnt;
                        r_dst       <= u_pos;
                        r_end       <= r_cnt_cur - CNT_W'(2);
                        if (r_found) begin
                            r_counts[PIDX_W'(r_player)] <= u_newcnt;
                        end
                    end
                end
            end

            if (r_state == S_MOVE) begin
                if (r_mv_more) begin
                    r_wr_v   <= 1'b1;
                    r_wr_dst <= r_dst;
                    if (r_dst == r_end) begin
                        r_mv_more <= 1'b0;
                    end else begin
                        r_dst <= mv_src;
                    end
                end else begin
                    r_wr_v <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= s_axis_tuser;
            r_player <= in_player;
            r_id     <= in_id;
            r_prio   <= in_prio;
            r_fade   <= in_fade;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.depth, r_out.fade, r_out.prio,
                                         r_out.id, r_out.player});

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt_cur <= CNT_W'(LIST_DEPTH)))
        else $error("list count above list depth");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("entry shift reads the word it writes");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final result");

    a_head_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && r_start_ram) |-> (r_cnt_cur != '0))
        else $error("start of a head in an empty list");

endmodule

>>> hw/rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
